### sv/fat_root_dir_file_locator_macros.svh
// assertion helpers, sampled on clk and held off while rst_n is low
`ifndef FAT_ROOT_DIR_FILE_LOCATOR_MACROS_SVH
`define FAT_ROOT_DIR_FILE_LOCATOR_MACROS_SVH

// same-cycle implication
`define FATRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FATRD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fatrd_pkg.sv
`timescale 1ns / 1ps
package fatrd_pkg;

  // fixed geometry
  localparam int SECTOR_BYTES     = 512;
  localparam int MAX_ROOT_SECTORS = 64;
  localparam int ENTRY_BYTES      = 32;
  localparam int SECTOR_SHIFT     = $clog2(SECTOR_BYTES);
  localparam int ENT_PER_SEC      = SECTOR_BYTES / ENTRY_BYTES;
  localparam int ENT_SHIFT        = $clog2(ENT_PER_SEC);
  localparam int RS_W             = $clog2(MAX_ROOT_SECTORS + 1);
  localparam int BCNT_W           = $clog2(SECTOR_BYTES);
  localparam int EPOS_W           = $clog2(ENTRY_BYTES);
  localparam logic [15:0] SECTOR_BYTES_W = 16'(SECTOR_BYTES);

  // widths
  localparam int NAME_W     = 64;
  localparam int EXT_W      = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;
  localparam int OFF_W      = 35;
  localparam int SSUM_W     = 25;
  localparam int ROFF_W     = SSUM_W + SECTOR_SHIFT;
  localparam int PROD_W     = 24;

  // queue depths
  localparam int CMD_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NAME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXT  = 1'b1;
  localparam logic [NAME_W-1:0] NAME_RESET = 64'd2314885638966561872;
  localparam logic [EXT_W-1:0]  EXT_RESET  = 24'd5396046;

  // jump signature
  localparam logic [7:0] SIG0 = 8'hEB;
  localparam logic [7:0] SIG1 = 8'h3C;
  localparam logic [7:0] SIG2 = 8'h90;

  // boot sector byte positions
  localparam logic [BCNT_W-1:0] BP_SIG0    = BCNT_W'(0);
  localparam logic [BCNT_W-1:0] BP_SIG1    = BCNT_W'(1);
  localparam logic [BCNT_W-1:0] BP_SIG2    = BCNT_W'(2);
  localparam logic [BCNT_W-1:0] BP_SSZ_LO  = BCNT_W'(11);
  localparam logic [BCNT_W-1:0] BP_SSZ_HI  = BCNT_W'(12);
  localparam logic [BCNT_W-1:0] BP_CSEC    = BCNT_W'(13);
  localparam logic [BCNT_W-1:0] BP_RES_LO  = BCNT_W'(14);
  localparam logic [BCNT_W-1:0] BP_RES_HI  = BCNT_W'(15);
  localparam logic [BCNT_W-1:0] BP_FATS    = BCNT_W'(16);
  localparam logic [BCNT_W-1:0] BP_ROOT_LO = BCNT_W'(17);
  localparam logic [BCNT_W-1:0] BP_ROOT_HI = BCNT_W'(18);
  localparam logic [BCNT_W-1:0] BP_FSZ_LO  = BCNT_W'(22);
  localparam logic [BCNT_W-1:0] BP_FSZ_HI  = BCNT_W'(23);
  localparam logic [BCNT_W-1:0] BP_LAST    = BCNT_W'(SECTOR_BYTES - 1);

  // directory entry byte positions
  localparam logic [EPOS_W-1:0] RP_NAME_END = EPOS_W'(8);
  localparam logic [EPOS_W-1:0] RP_EXT_END  = EPOS_W'(11);
  localparam logic [EPOS_W-1:0] RP_CLUS_LO  = EPOS_W'(26);
  localparam logic [EPOS_W-1:0] RP_CLUS_HI  = EPOS_W'(27);
  localparam logic [EPOS_W-1:0] RP_LAST     = EPOS_W'(ENTRY_BYTES - 1);

  // result codes
  localparam logic [1:0] EV_ROOT = 2'd0;
  localparam logic [1:0] EV_FILE = 2'd1;
  localparam logic [1:0] EV_FAIL = 2'd2;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_SIG   = 3'd1;
  localparam logic [2:0] ERR_SSZ   = 3'd2;
  localparam logic [2:0] ERR_RSZ   = 3'd3;
  localparam logic [2:0] ERR_NOTFD = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BOOT,
    PH_ROOT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       event_res;
    logic [2:0]       error_code;
    logic [OFF_W-1:0] byte_offset;
  } out_item_t;

  // request from front to back: base offset plus cluster term still to add
  typedef struct packed {
    logic [1:0]       event_res;
    logic [2:0]       error_code;
    logic [OFF_W-1:0] base;
    logic [15:0]      clus_idx;
    logic [7:0]       clus_sec;
  } cmd_t;

endpackage

### sv/fat_root_dir_file_locator.sv
`timescale 1ns / 1ps
// FAT12/FAT16 root directory file lookup. Disk bytes go in at up to one per clock;
// a byte flagged first_byte starts a search at byte 0 of a boot sector. The
// block checks the jump signature, a 512-byte sector and a root of 1 to 64
// sectors, reports the root directory offset on the last boot sector byte,
// then compares every 32-byte entry with the configured 8.3 name and reports
// the first match's data offset, or a failure. A result shows on the output
// queue via the request queue and the offset unit. full rises only when the
// request queue between the byte parser and the offset unit holds CMD_DEPTH
// requests, which happens only while results wait unpopped in the output
// queue. Write the name registers only while no search is running.
module fat_root_dir_file_locator #(
  parameter int CMD_DEPTH = fatrd_pkg::CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = fatrd_pkg::OUT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // byte channel
  input  logic                             push,
  input  fatrd_pkg::in_item_t              in_data,
  output logic                             full,
  // result channel
  output logic                             empty,
  output fatrd_pkg::out_item_t             out_data,
  input  logic                             pop,
  // name registers
  input  logic                             cfg_we,
  input  logic [fatrd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fatrd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fatrd_pkg::*;

`include "fat_root_dir_file_locator_macros.svh"

  // front to back request queue
  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t      cmd_wdata, cmd_rdata;

  // back to output queue
  logic      res_push, res_full;
  out_item_t res_data;

  // byte parser: phase tracking, field capture, name compare
  fatrd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wdata),
    .cmd_full (cmd_full)
  );

  fatrd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  // offset unit: cluster multiply then final add
  fatrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  // result queue, its head drives the output ports
  fatrd_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

  // requests come only from accepted bytes and never overrun their queues
  `FATRD_ASSERT_IMP(a_cmd_from_byte, cmd_push, push && !full, "request without byte")
  `FATRD_ASSERT_IMP(a_cmd_no_ovf, cmd_push, !cmd_full, "request queue overflow")
  `FATRD_ASSERT_IMP(a_res_no_ovf, res_push, !res_full, "result queue overflow")
  // successful events carry no error code
  `FATRD_ASSERT_IMP(a_ok_no_err, !empty && (out_data.event_res != EV_FAIL),
                    out_data.error_code == ERR_NONE, "error code on success")

endmodule

### sv/fatrd_fifo.sv
`timescale 1ns / 1ps
module fatrd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### sv/fatrd_front.sv
`timescale 1ns / 1ps
module fatrd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  fatrd_pkg::in_item_t            in_data,
  output logic                           full,
  input  logic                           cfg_we,
  input  logic [fatrd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [fatrd_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           cmd_push,
  output fatrd_pkg::cmd_t                cmd_data,
  input  logic                           cmd_full
);
  import fatrd_pkg::*;

  phase_t              phase_r, phase_nxt, cur_ph;
  logic [BCNT_W-1:0]   cnt_r, cnt_nxt, pos;
  logic [EPOS_W-1:0]   rpos;
  logic [7:0]          b;
  logic                acc, is_boot, is_root;

  logic [NAME_W-1:0]   name_r;
  logic [EXT_W-1:0]    ext_r;

  logic                hdr_ok_r, hdr_ok_nxt;
  logic [7:0]          csec_r, csec_nxt;
  logic [15:0]         res_r, res_nxt;
  logic [7:0]          fats_r, fats_nxt;
  logic [15:0]         fsz_r, fsz_nxt;
  logic [15:0]         re_r, re_nxt;
  logic [RS_W-1:0]     rsec_r, rsec_nxt;
  logic [ROFF_W-1:0]   roff_r, roff_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic [OFF_W-1:0]    dbase_r;
  logic                ematch_r, ematch_nxt;
  logic [15:0]         clus_r, clus_nxt;
  logic [15:0]         seen_r, seen_nxt, seen_inc;

  logic [16:0]         re_sum, rs_calc;
  logic [SSUM_W-1:0]   sec_sum;
  logic [ROFF_W-1:0]   roff_calc;
  logic                byte_eq, match_now;
  logic                f_sig, f_ssz, f_rsz, boot_last;
  logic                ent_last, file_hit, clus_fail, end_fail;

  assign full    = cmd_full;
  assign acc     = push && !cmd_full;
  assign cur_ph  = in_data.first_byte ? PH_BOOT : phase_r;
  assign pos     = in_data.first_byte ? '0 : cnt_r;
  assign rpos    = pos[EPOS_W-1:0];
  assign b       = in_data.data_byte;
  assign is_boot = acc && (cur_ph == PH_BOOT);
  assign is_root = acc && (cur_ph == PH_ROOT);

  // decode of the current byte
  always_comb begin
    re_sum    = {1'b0, b, re_r[7:0]} + 17'(ENT_PER_SEC - 1);
    rs_calc   = re_sum >> ENT_SHIFT;
    sec_sum   = SSUM_W'(res_r) + SSUM_W'(prod_r);
    roff_calc = ROFF_W'(sec_sum) << SECTOR_SHIFT;
    seen_inc  = seen_r + 16'd1;

    if (rpos < RP_NAME_END) begin
      byte_eq = (b == name_r[{rpos[2:0], 3'b000} +: 8]);
    end else if (rpos < RP_EXT_END) begin
      byte_eq = (b == ext_r[{rpos[1:0], 3'b000} +: 8]);
    end else begin
      byte_eq = 1'b1;
    end
    match_now = ematch_r && byte_eq;

    f_sig     = is_boot && (pos == BP_SIG2) && !(hdr_ok_r && (b == SIG2));
    f_ssz     = is_boot && (pos == BP_SSZ_HI) && !(hdr_ok_r && (b == SECTOR_BYTES_W[15:8]));
    f_rsz     = is_boot && (pos == BP_ROOT_HI) &&
                ((rs_calc == '0) || (rs_calc > 17'(MAX_ROOT_SECTORS)));
    boot_last = is_boot && (pos == BP_LAST);

    ent_last  = is_root && (rpos == RP_LAST);
    file_hit  = ent_last && match_now && (clus_r >= 16'd2);
    clus_fail = ent_last && match_now && (clus_r < 16'd2);
    end_fail  = ent_last && !match_now && (seen_inc >= re_r);
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (cur_ph)
        PH_IDLE: phase_nxt = PH_IDLE;
        PH_BOOT: begin
          if (f_sig || f_ssz || f_rsz) begin
            phase_nxt = PH_DONE;
          end else if (boot_last) begin
            phase_nxt = PH_ROOT;
          end else begin
            phase_nxt = PH_BOOT;
          end
        end
        PH_ROOT: begin
          if (file_hit || clus_fail || end_fail) begin
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_ROOT;
          end
        end
        PH_DONE: phase_nxt = PH_DONE;
      endcase
    end
  end

  // field captures and counters
  always_comb begin
    cnt_nxt    = cnt_r;
    hdr_ok_nxt = hdr_ok_r;
    csec_nxt   = csec_r;
    res_nxt    = res_r;
    fats_nxt   = fats_r;
    fsz_nxt    = fsz_r;
    re_nxt     = re_r;
    rsec_nxt   = rsec_r;
    roff_nxt   = roff_r;
    ematch_nxt = ematch_r;
    clus_nxt   = clus_r;
    seen_nxt   = seen_r;
    if (is_boot) begin
      cnt_nxt = pos + 1'b1;
      case (pos)
        BP_SIG0:    hdr_ok_nxt = (b == SIG0);
        BP_SIG1:    hdr_ok_nxt = hdr_ok_r && (b == SIG1);
        BP_SSZ_LO:  hdr_ok_nxt = (b == SECTOR_BYTES_W[7:0]);
        BP_CSEC:    csec_nxt = b;
        BP_RES_LO:  res_nxt = {8'h00, b};
        BP_RES_HI:  res_nxt = {b, res_r[7:0]};
        BP_FATS:    fats_nxt = b;
        BP_ROOT_LO: re_nxt = {8'h00, b};
        BP_ROOT_HI: begin
          re_nxt   = {b, re_r[7:0]};
          rsec_nxt = rs_calc[RS_W-1:0];
        end
        BP_FSZ_LO:  fsz_nxt = {8'h00, b};
        BP_FSZ_HI:  fsz_nxt = {b, fsz_r[7:0]};
        default:    ;
      endcase
      if (boot_last) begin
        cnt_nxt    = '0;
        roff_nxt   = roff_calc;
        ematch_nxt = 1'b1;
        seen_nxt   = '0;
      end
    end else if (is_root) begin
      cnt_nxt = BCNT_W'(rpos + 1'b1);
      if (rpos == RP_CLUS_LO) begin
        clus_nxt = {8'h00, b};
      end else if (rpos == RP_CLUS_HI) begin
        clus_nxt = {b, clus_r[7:0]};
      end
      if (ent_last) begin
        ematch_nxt = 1'b1;
        if (!match_now) begin
          seen_nxt = seen_inc;
        end
      end else begin
        ematch_nxt = match_now;
      end
    end
  end

  // request to the back end
  always_comb begin
    cmd_push = f_sig || f_ssz || f_rsz || boot_last || file_hit || clus_fail || end_fail;
    cmd_data = '0;
    if (f_sig) begin
      cmd_data.event_res  = EV_FAIL;
      cmd_data.error_code = ERR_SIG;
    end else if (f_ssz) begin
      cmd_data.event_res  = EV_FAIL;
      cmd_data.error_code = ERR_SSZ;
    end else if (f_rsz) begin
      cmd_data.event_res  = EV_FAIL;
      cmd_data.error_code = ERR_RSZ;
    end else if (boot_last) begin
      cmd_data.event_res  = EV_ROOT;
      cmd_data.error_code = ERR_NONE;
      cmd_data.base       = OFF_W'(roff_calc);
    end else if (file_hit) begin
      cmd_data.event_res  = EV_FILE;
      cmd_data.error_code = ERR_NONE;
      cmd_data.base       = dbase_r;
      cmd_data.clus_idx   = clus_r - 16'd2;
      cmd_data.clus_sec   = csec_r;
    end else if (clus_fail || end_fail) begin
      cmd_data.event_res  = EV_FAIL;
      cmd_data.error_code = ERR_NOTFD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= '0;
      hdr_ok_r <= 1'b1;
      ematch_r <= 1'b1;
      name_r   <= NAME_RESET;
      ext_r    <= EXT_RESET;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      ematch_r <= ematch_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_IDX_NAME: name_r <= cfg_data[NAME_W-1:0];
          CFG_IDX_EXT:  ext_r  <= cfg_data[EXT_W-1:0];
        endcase
      end
    end
  end

  // payload registers; the product and data base settle long before use
  always_ff @(posedge clk) begin
    csec_r  <= csec_nxt;
    res_r   <= res_nxt;
    fats_r  <= fats_nxt;
    fsz_r   <= fsz_nxt;
    re_r    <= re_nxt;
    rsec_r  <= rsec_nxt;
    roff_r  <= roff_nxt;
    clus_r  <= clus_nxt;
    seen_r  <= seen_nxt;
    prod_r  <= fats_r * fsz_r;
    dbase_r <= OFF_W'(roff_r) + (OFF_W'(rsec_r) << SECTOR_SHIFT);
  end

endmodule

### sv/fatrd_back.sv
`timescale 1ns / 1ps
module fatrd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_empty,
  input  fatrd_pkg::cmd_t      cmd_data,
  output logic                 cmd_pop,
  output logic                 res_push,
  output fatrd_pkg::out_item_t res_data,
  input  logic                 res_full
);
  import fatrd_pkg::*;

  logic              s1_vld_r;
  logic [1:0]        s1_ev_r;
  logic [2:0]        s1_err_r;
  logic [OFF_W-1:0]  s1_base_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic              adv;

  assign adv      = !s1_vld_r || !res_full;
  assign cmd_pop  = adv && !cmd_empty;
  assign res_push = s1_vld_r && !res_full;

  always_comb begin
    res_data.event_res   = s1_ev_r;
    res_data.error_code  = s1_err_r;
    res_data.byte_offset = s1_base_r + (OFF_W'(s1_prod_r) << SECTOR_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= !cmd_empty;
    end
  end

  // cluster index times cluster size, registered before the final add
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_ev_r   <= cmd_data.event_res;
      s1_err_r  <= cmd_data.error_code;
      s1_base_r <= cmd_data.base;
      s1_prod_r <= PROD_W'(cmd_data.clus_idx) * PROD_W'(cmd_data.clus_sec);
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fatrd_pkg::*;

  // cluster numbering starts at two, lower values mean no data
  localparam int FIRST_DATA_CLUSTER = 2;
  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] UNUSED_MARK  = 8'h00;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] LETTER_A     = 8'h41;

  logic                  clk;
  logic                  rst_n    = 1'b0;
  logic                  push     = 1'b0;
  in_item_t              in_data  = '0;
  logic                  full;
  logic                  empty;
  out_item_t             out_data;
  logic                  pop      = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fat_root_dir_file_locator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .empty    (empty),
    .out_data (out_data),
    .pop      (pop),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // disk bytes waiting to be sent, one request each
  in_item_t  disk_bytes[$];
  // lookup events the block still owes, oldest first
  out_item_t expected_events[$];
  // scratch image of the sector or directory being built
  logic [7:0] seq_img[$];

  int  items_planned = 0;
  int  results_seen  = 0;
  int  mismatches    = 0;
  int  tx_hold       = 0;
  int  rx_hold       = 0;
  // stretches with no idling on either side
  bit  tx_burst      = 1'b0;
  bit  rx_burst      = 1'b0;

  // ---------------------------------------------------------------------
  // lookup predictor: own copy of the search state and the target name
  // ---------------------------------------------------------------------
  logic [NAME_W-1:0] tgt_name   = NAME_RESET;
  logic [EXT_W-1:0]  tgt_ext    = EXT_RESET;
  phase_t            lk_phase   = PH_IDLE;
  logic [15:0]       scan_pos   = '0;
  logic [15:0]       resv_secs  = '0;
  logic [7:0]        fat_num    = '0;
  logic [15:0]       fat_secs   = '0;
  logic [15:0]       root_ents  = '0;
  logic [7:0]        clus_secs  = '0;
  bit                hdr_ok     = 1'b1;
  logic [33:0]       root_off   = '0;
  bit                name_hit   = 1'b1;
  logic [15:0]       hit_clus   = '0;
  logic [15:0]       ents_done  = '0;

  // root directory size in sectors, rounded up
  function automatic int unsigned root_secs();
    return (int'(root_ents) * ENTRY_BYTES + SECTOR_BYTES - 1) / SECTOR_BYTES;
  endfunction

  function automatic bit search_fails(input logic [2:0] err, output out_item_t res);
    lk_phase = PH_DONE;
    res.event_res   = EV_FAIL;
    res.error_code  = err;
    res.byte_offset = '0;
    return 1'b1;
  endfunction

  // advances the search by one disk byte, returns 1 when an event is due
  function automatic bit locate_step(input in_item_t it, output out_item_t res);
    logic [7:0]  b;
    logic [15:0] pos;
    logic [4:0]  epos;
    logic [63:0] off;
    b   = it.data_byte;
    res = '0;
    // a marked byte always restarts from byte 0 of a boot sector
    if (it.first_byte) begin
      lk_phase  = PH_BOOT;
      scan_pos  = '0;
      resv_secs = '0;
      fat_num   = '0;
      fat_secs  = '0;
      root_ents = '0;
      clus_secs = '0;
      hdr_ok    = 1'b1;
      root_off  = '0;
      name_hit  = 1'b1;
      hit_clus  = '0;
      ents_done = '0;
    end
    if (lk_phase == PH_BOOT) begin
      pos      = scan_pos;
      scan_pos = scan_pos + 16'd1;
      case (pos)
        BP_SIG0: hdr_ok = (b == SIG0);
        BP_SIG1: hdr_ok = hdr_ok && (b == SIG1);
        BP_SIG2: if (!(hdr_ok && b == SIG2)) return search_fails(ERR_SIG, res);
        BP_SSZ_LO: hdr_ok = (b == SECTOR_BYTES_W[7:0]);
        BP_SSZ_HI: if (!(hdr_ok && b == SECTOR_BYTES_W[15:8])) return search_fails(ERR_SSZ, res);
        BP_CSEC:   clus_secs = b;
        BP_RES_LO: resv_secs[7:0] = b;
        BP_RES_HI: resv_secs[15:8] = b;
        BP_FATS:   fat_num = b;
        BP_ROOT_LO: root_ents[7:0] = b;
        BP_ROOT_HI: begin
          root_ents[15:8] = b;
          if (root_secs() == 0 || root_secs() > MAX_ROOT_SECTORS)
            return search_fails(ERR_RSZ, res);
        end
        BP_FSZ_LO: fat_secs[7:0] = b;
        BP_FSZ_HI: fat_secs[15:8] = b;
        default: ;
      endcase
      // last boot byte: root directory located, entries follow
      if (pos == BP_LAST) begin
        off       = (64'(resv_secs) + 64'(fat_num) * 64'(fat_secs)) * SECTOR_BYTES;
        root_off  = off[33:0];
        lk_phase  = PH_ROOT;
        scan_pos  = '0;
        name_hit  = 1'b1;
        hit_clus  = '0;
        ents_done = '0;
        res.event_res   = EV_ROOT;
        res.error_code  = ERR_NONE;
        res.byte_offset = OFF_W'(off);
        return 1'b1;
      end
      return 1'b0;
    end
    if (lk_phase == PH_ROOT) begin
      epos = scan_pos[4:0];
      if (epos < RP_NAME_END) begin
        if (b != tgt_name[8*epos +: 8]) name_hit = 1'b0;
      end else if (epos < RP_EXT_END) begin
        if (b != tgt_ext[8*(epos - RP_NAME_END) +: 8]) name_hit = 1'b0;
      end else if (epos == RP_CLUS_LO) begin
        hit_clus = {8'h00, b};
      end else if (epos == RP_CLUS_HI) begin
        hit_clus[15:8] = b;
      end
      scan_pos = 16'(epos) + 16'd1;
      if (epos != RP_LAST) return 1'b0;
      // entry complete: decide on it
      scan_pos = '0;
      if (name_hit) begin
        if (hit_clus < FIRST_DATA_CLUSTER) return search_fails(ERR_NOTFD, res);
        off = 64'(root_off) + 64'(root_secs()) * SECTOR_BYTES +
              (64'(hit_clus) - FIRST_DATA_CLUSTER) * SECTOR_BYTES * 64'(clus_secs);
        lk_phase = PH_DONE;
        res.event_res   = EV_FILE;
        res.error_code  = ERR_NONE;
        res.byte_offset = OFF_W'(off);
        return 1'b1;
      end
      name_hit  = 1'b1;
      ents_done = ents_done + 16'd1;
      if (ents_done >= root_ents) return search_fails(ERR_NOTFD, res);
      return 1'b0;
    end
    // idle or finished: byte ignored
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // driver: byte requests from the disk_bytes queue, random gap per byte
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t res;
    if (!rst_n) begin
      push <= 1'b0;
      tx_hold = 0;
    end else begin
      // request taken at this edge: predict what it causes
      if (push && !full) begin
        if (locate_step(in_data, res)) expected_events.push_back(res);
      end
      // hold the request while the block is full
      if (!(push && full)) begin
        if (tx_hold > 0) begin
          tx_hold--;
          push <= 1'b0;
        end else if (disk_bytes.size() != 0) begin
          in_data <= disk_bytes.pop_front();
          push    <= 1'b1;
          tx_hold = tx_burst ? 0 : $urandom_range(0, 9);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: pops results with random stalls, checks field by field
  // ---------------------------------------------------------------------
  task automatic flag_field(input string fld, input logic [63:0] want, input logic [63:0] got);
    if (want != got) begin
      $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, fld, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      pop <= 1'b0;
      rx_hold = 0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          $display("%0t ns: unexpected result expected none actual event %0d error %0d offset 0x%0h",
                   $time, out_data.event_res, out_data.error_code, out_data.byte_offset);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          flag_field("event_res", want.event_res, out_data.event_res);
          flag_field("error_code", want.error_code, out_data.error_code);
          flag_field("byte_offset", want.byte_offset, out_data.byte_offset);
        end
        rx_hold = rx_burst ? 0 : $urandom_range(0, 9);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  // counted bytes are the ones the block acts on
  task automatic put(input logic [7:0] b, input bit fb, input bit counted);
    in_item_t it;
    it.data_byte  = b;
    it.first_byte = fb;
    disk_bytes.push_back(it);
    if (counted) items_planned++;
  endtask

  // sends the first keep bytes of the image, the first one marked
  task automatic send_seq(input int keep);
    for (int i = 0; i < keep; i++) put(seq_img[i], i == 0, 1'b1);
  endtask

  // valid boot sector with random geometry and the given root entry count
  task automatic build_boot(input logic [15:0] ents);
    logic [15:0] resv;
    logic [15:0] fsz;
    logic [7:0]  csz;
    logic [7:0]  nf;
    case ($urandom_range(0, 3))
      0: csz = 8'd0;
      1: csz = 8'd1;
      2: csz = 8'hFF;
      default: csz = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: resv = 16'd0;
      1: resv = 16'hFFFF;
      2: resv = 16'($urandom_range(1, 32));
      default: resv = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: nf = 8'd0;
      1: nf = 8'd2;
      2: nf = 8'hFF;
      default: nf = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: fsz = 16'd0;
      1: fsz = 16'hFFFF;
      2: fsz = 16'($urandom_range(1, 300));
      default: fsz = 16'($urandom);
    endcase
    seq_img.delete();
    repeat (SECTOR_BYTES) seq_img.push_back(8'($urandom));
    seq_img[BP_SIG0]    = SIG0;
    seq_img[BP_SIG1]    = SIG1;
    seq_img[BP_SIG2]    = SIG2;
    seq_img[BP_SSZ_LO]  = SECTOR_BYTES_W[7:0];
    seq_img[BP_SSZ_HI]  = SECTOR_BYTES_W[15:8];
    seq_img[BP_CSEC]    = csz;
    seq_img[BP_RES_LO]  = resv[7:0];
    seq_img[BP_RES_HI]  = resv[15:8];
    seq_img[BP_FATS]    = nf;
    seq_img[BP_ROOT_LO] = ents[7:0];
    seq_img[BP_ROOT_HI] = ents[15:8];
    seq_img[BP_FSZ_LO]  = fsz[7:0];
    seq_img[BP_FSZ_HI]  = fsz[15:8];
  endtask

  // one 32-byte directory entry, either the target name or a miss
  task automatic add_entry(input bit is_hit, input logic [15:0] clus);
    logic [7:0] ent [ENTRY_BYTES];
    int p;
    foreach (ent[i]) ent[i] = 8'($urandom);
    for (int i = 0; i < 8; i++) ent[i] = tgt_name[8*i +: 8];
    for (int i = 0; i < 3; i++) ent[8 + i] = tgt_ext[8*i +: 8];
    if (!is_hit) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 11; i++) ent[i] = 8'($urandom);
      end else begin
        // one character off, sometimes also marked deleted or unused
        p = $urandom_range(0, 10);
        ent[p] = ent[p] ^ 8'($urandom_range(1, 255));
        if (p != 0 && $urandom_range(0, 2) == 0)
          ent[0] = $urandom_range(0, 1) ? DELETED_MARK : UNUSED_MARK;
      end
    end
    ent[RP_CLUS_LO] = clus[7:0];
    ent[RP_CLUS_HI] = clus[15:8];
    foreach (ent[i]) seq_img.push_back(ent[i]);
  endtask

  // one search attempt: broken header or noise, or a full well-formed search
  task automatic gen_sequence(input bit full_ok);
    int pick;
    int mode;
    int k;
    int keep;
    logic [15:0] ents;
    logic [15:0] clus;
    pick = full_ok ? 99 : $urandom_range(0, 53);
    if (pick < 18) begin
      // jump signature broken at one of its three bytes
      build_boot(16'd1);
      k = $urandom_range(0, 2);
      seq_img[k] = seq_img[k] ^ 8'($urandom_range(1, 255));
      send_seq(3);
    end else if (pick < 32) begin
      // wrong sector size
      build_boot(16'd1);
      case ($urandom_range(0, 3))
        0: seq_img[BP_SSZ_LO] = 8'($urandom_range(1, 255));
        1: seq_img[BP_SSZ_HI] = 8'h01;
        2: seq_img[BP_SSZ_HI] = 8'h04 << $urandom_range(0, 5);
        default: begin
          seq_img[BP_SSZ_LO] = 8'($urandom);
          seq_img[BP_SSZ_HI] = 8'($urandom);
        end
      endcase
      send_seq(int'(BP_SSZ_HI) + 1);
    end else if (pick < 46) begin
      // root size of zero or beyond the limit
      case ($urandom_range(0, 3))
        0: ents = 16'd0;
        1: ents = 16'(MAX_ROOT_SECTORS * ENT_PER_SEC + 1);
        2: ents = 16'hFFFF;
        default: ents = 16'($urandom_range(MAX_ROOT_SECTORS * ENT_PER_SEC + 1, 65535));
      endcase
      build_boot(ents);
      send_seq(int'(BP_ROOT_HI) + 1);
    end else if (pick < 54) begin
      // unmarked noise, mostly ignored
      repeat ($urandom_range(1, 20)) put(8'($urandom), 1'b0, 1'b0);
    end else begin
      // full search: 0-5 found, 6-7 absent, 8 start cluster below two, 9 cut short
      mode = $urandom_range(0, 9);
      if (mode == 6 || mode == 7) begin
        ents = 16'($urandom_range(1, 6));
      end else begin
        case ($urandom_range(0, 5))
          0: ents = 16'd1;
          1: ents = 16'(ENT_PER_SEC);
          2: ents = 16'(ENT_PER_SEC + 1);
          3: ents = 16'(MAX_ROOT_SECTORS * ENT_PER_SEC);
          default: ents = 16'($urandom_range(1, 64));
        endcase
      end
      build_boot(ents);
      if (mode == 6 || mode == 7) begin
        for (int i = 0; i < ents; i++) add_entry(1'b0, 16'($urandom));
      end else begin
        k = $urandom_range(0, (ents > 6) ? 5 : int'(ents) - 1);
        for (int i = 0; i < k; i++) add_entry(1'b0, 16'($urandom));
        if (mode == 8) begin
          clus = 16'($urandom_range(0, FIRST_DATA_CLUSTER - 1));
        end else begin
          case ($urandom_range(0, 3))
            0: clus = 16'(FIRST_DATA_CLUSTER);
            1: clus = 16'hFFFF;
            2: clus = 16'($urandom_range(FIRST_DATA_CLUSTER, 100));
            default: clus = 16'($urandom_range(FIRST_DATA_CLUSTER, 65535));
          endcase
        end
        add_entry(1'b1, clus);
      end
      keep = seq_img.size();
      if (mode == 9) keep = $urandom_range(1, keep - 1);
      send_seq(keep);
      // trailing bytes after the decision are ignored
      if (mode != 9) repeat ($urandom_range(0, 8)) put(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  // n_full full searches first, then short sequences until n_items bytes are queued
  task automatic run_random(input int n_items, input int n_full);
    int start_items;
    start_items = items_planned;
    for (int i = 0; i < n_full; i++) begin
      while (disk_bytes.size() > 40) @(negedge clk);
      tx_burst = ($urandom_range(0, 4) == 0);
      rx_burst = ($urandom_range(0, 4) == 0);
      gen_sequence(1'b1);
    end
    while (items_planned - start_items < n_items) begin
      // keep only a short backlog so the idle choice follows the sequence
      while (disk_bytes.size() > 40) @(negedge clk);
      tx_burst = ($urandom_range(0, 4) == 0);
      rx_burst = ($urandom_range(0, 4) == 0);
      gen_sequence(1'b0);
    end
  endtask

  // closes any open search, then lets the block drain completely
  task automatic settle();
    put(~SIG0, 1'b1, 1'b1);
    put(SIG1, 1'b0, 1'b1);
    put(SIG2, 1'b0, 1'b1);
    do @(negedge clk);
    while (disk_bytes.size() != 0 || push || expected_events.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  // register write, block is idle here so the predictor copy follows at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (idx == CFG_IDX_NAME) tgt_name = v;
    else tgt_ext = v[EXT_W-1:0];
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [NAME_W-1:0] nm;
    logic [EXT_W-1:0]  ex;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ignored bytes, each broken signature byte, restart mid-header
    put(8'hFF, 1'b0, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'h00, 1'b1, 1'b1);
    put(SIG1, 1'b0, 1'b1);
    put(SIG2, 1'b0, 1'b1);
    put(SIG0, 1'b0, 1'b0);
    put(SIG0, 1'b1, 1'b1);
    put(8'hFF, 1'b0, 1'b1);
    put(SIG2, 1'b0, 1'b1);
    put(SIG0, 1'b1, 1'b1);
    put(SIG1, 1'b0, 1'b1);
    put(8'h00, 1'b0, 1'b1);
    put(SIG0, 1'b1, 1'b1);
    put(SIG1, 1'b0, 1'b1);
    put(SIG0, 1'b1, 1'b1);
    put(SIG1, 1'b0, 1'b1);
    put(8'hFF, 1'b0, 1'b1);

    // one pass per name setting, reset value first; the last pass runs a full search
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        // sender holds off until every event is in
        settle();
        case (ph)
          1: begin
            nm = '0;
            ex = '0;
          end
          2: begin
            nm = '1;
            ex = '1;
          end
          3: begin
            nm = {$urandom, $urandom};
            ex = EXT_W'($urandom);
          end
          default: begin
            // readable space-padded 8.3 name
            nm = {8{SPACE_CHAR}};
            ex = {3{SPACE_CHAR}};
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) nm[8*i +: 8] = LETTER_A + 8'($urandom_range(0, 25));
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) ex[8*i +: 8] = LETTER_A + 8'($urandom_range(0, 25));
          end
        endcase
        write_reg(CFG_IDX_NAME, nm);
        // upper data bits beyond the extension must not matter
        write_reg(CFG_IDX_EXT, (ph == 2) ? '1 : {$urandom, 8'($urandom), ex});
      end
      if (ph == 4) run_random(600, 1);
      else run_random(80, 0);
    end

    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #(8_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/fatrd_pkg.sv
sv/fatrd_fifo.sv
sv/fatrd_front.sv
sv/fatrd_back.sv
sv/fat_root_dir_file_locator.sv
sim/tb_top.sv
